FILE: design/irc_tok_pkg.sv
// ----------------------------------------------------------------------------
// irc_tok_pkg
// shared types and constants of the irc line tokenizer
// ----------------------------------------------------------------------------
package irc_tok_pkg;

	localparam int MAX_ARGS_DEF = 15;

	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [9:0] REPLY_MAX = 10'd999;

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_NAME     = 3'd1,
		PH_USER     = 3'd2,
		PH_HOST     = 3'd3,
		PH_CMD      = 3'd4,
		PH_ARGSTART = 3'd5,
		PH_ARGBODY  = 3'd6,
		PH_TRAIL    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		TAG_DELIM = 3'd0,
		TAG_NAME  = 3'd1,
		TAG_USER  = 3'd2,
		TAG_HOST  = 3'd3,
		TAG_CMD   = 3'd4,
		TAG_ARG   = 3'd5,
		TAG_TRAIL = 3'd6
	} tag_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SERVER = 2'd1,
		KIND_NICK   = 2'd2
	} prefix_kind_t;

endpackage

FILE: design/irc_line_tokenizer.sv
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// tags each byte of an irc message line with its role in the message
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one byte of the line per request, crlf stripped, with
//   s_axis_tlast on the final byte. m_axis returns one request per input
//   byte: the byte and its tag, argument index, flags and reply code.
//   the prefix name, user and host, command, middle arguments and the
//   trailing argument are told apart; spaces and prefix marks are delimiters.
//   each byte passes an input register, then the parse logic and the
//   parser state feeding the result register. one byte per cycle is taken
//   as long as m_axis_tready is high; the state update is a single pass
//   over the registered byte.
//   when the receiver stalls the result register holds, the input register
//   fills, and s_axis_tready drops until the result is taken.
//   reset clears the valid flags of both registers and puts the parser at
//   line start; after the last byte of a line the parser returns to line start.
// ----------------------------------------------------------------------------
module irc_line_tokenizer #(
	parameter int MAX_ARGS = irc_tok_pkg::MAX_ARGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // byte_out[7:0], arg_number[11:8],
	                                   // closes_argument[12], invalid_line[13],
	                                   // reply_code[23:14]
	output logic [4:0]  m_axis_tuser,  // tag[2:0], prefix_kind[4:3]
	output logic        m_axis_tlast   // line_done
);

	localparam int ARG_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
	localparam logic [ARG_W-1:0] ARG_TOP = ARG_W'(MAX_ARGS - 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic       valid_s2;
	logic [7:0] byte_s2;
	logic       last_s2;
	logic [2:0] tag_s2;
	logic [3:0] argn_s2;
	logic       closes_s2;
	logic [1:0] kind_s2;
	logic       invalid_s2;
	logic [9:0] code_s2;

	// parser state
	irc_tok_pkg::phase_t phase_q, phase_d;
	logic                saw_dot_q, saw_dot_d;
	logic [ARG_W-1:0]    arg_count_q, arg_count_d;
	logic [9:0]          code_q, code_d;
	logic                digits_ended_q, digits_ended_d;

	logic advance_s2;
	logic advance_s1;

	assign advance_s2    = !valid_s2 || m_axis_tready;
	assign advance_s1    = valid_s1 && advance_s2;
	assign s_axis_tready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// byte class, reply code and argument count helpers
	logic        is_space;
	logic        is_digit;
	logic [13:0] code_mac;
	logic [9:0]  code_sat;
	logic        arg_room;

	assign is_space = (byte_s1 == irc_tok_pkg::CH_SPACE);
	assign is_digit = (byte_s1 >= irc_tok_pkg::CH_ZERO) && (byte_s1 <= irc_tok_pkg::CH_NINE);
	assign code_mac = {4'b0, code_q} * 14'd10 + {6'b0, byte_s1 - irc_tok_pkg::CH_ZERO};
	assign code_sat = (code_mac > {4'b0, irc_tok_pkg::REPLY_MAX}) ?
	                  irc_tok_pkg::REPLY_MAX : code_mac[9:0];
	assign arg_room = (arg_count_q < ARG_TOP);

	// next state
	always_comb begin
		phase_d        = phase_q;
		saw_dot_d      = saw_dot_q;
		arg_count_d    = arg_count_q;
		code_d         = code_q;
		digits_ended_d = digits_ended_q;
		unique case (phase_q)
			irc_tok_pkg::PH_NAME: begin
				if (byte_s1 == irc_tok_pkg::CH_BANG) begin
					phase_d = irc_tok_pkg::PH_USER;
				end else if (is_space) begin
					phase_d = irc_tok_pkg::PH_CMD;
				end else if (byte_s1 == irc_tok_pkg::CH_DOT) begin
					saw_dot_d = 1'b1;
				end
			end
			irc_tok_pkg::PH_USER: begin
				if (byte_s1 == irc_tok_pkg::CH_AT) begin
					phase_d = irc_tok_pkg::PH_HOST;
				end else if (is_space) begin
					phase_d = irc_tok_pkg::PH_CMD;
				end
			end
			irc_tok_pkg::PH_HOST: begin
				if (is_space) begin
					phase_d = irc_tok_pkg::PH_CMD;
				end
			end
			irc_tok_pkg::PH_START, irc_tok_pkg::PH_CMD: begin
				if (phase_q == irc_tok_pkg::PH_START && byte_s1 == irc_tok_pkg::CH_COLON) begin
					phase_d   = irc_tok_pkg::PH_NAME;
					saw_dot_d = 1'b0;
				end else if (is_space) begin
					phase_d = irc_tok_pkg::PH_ARGSTART;
				end else begin
					phase_d = irc_tok_pkg::PH_CMD;
					if (!digits_ended_q && is_digit) begin
						code_d = code_sat;
					end else begin
						digits_ended_d = 1'b1;
					end
				end
			end
			irc_tok_pkg::PH_ARGSTART: begin
				if (byte_s1 == irc_tok_pkg::CH_COLON) begin
					phase_d = irc_tok_pkg::PH_TRAIL;
				end else if (is_space) begin
					if (arg_room) begin
						arg_count_d = arg_count_q + 1'b1;
					end
				end else begin
					phase_d = irc_tok_pkg::PH_ARGBODY;
				end
			end
			irc_tok_pkg::PH_ARGBODY: begin
				if (is_space) begin
					phase_d = irc_tok_pkg::PH_ARGSTART;
					if (arg_room) begin
						arg_count_d = arg_count_q + 1'b1;
					end
				end
			end
			irc_tok_pkg::PH_TRAIL: begin
				phase_d = irc_tok_pkg::PH_TRAIL;
			end
			default: begin
				phase_d = irc_tok_pkg::PH_START;
			end
		endcase
	end

	// outputs
	irc_tok_pkg::tag_t         tag_c;
	irc_tok_pkg::prefix_kind_t kind_c;
	logic                      closes_c;
	logic                      in_args;
	logic [ARG_W+3:0]          arg_ext;
	logic [3:0]                argn_c;

	assign arg_ext = {4'b0, arg_count_q};
	assign in_args = (phase_q == irc_tok_pkg::PH_ARGSTART) ||
	                 (phase_q == irc_tok_pkg::PH_ARGBODY) ||
	                 (phase_q == irc_tok_pkg::PH_TRAIL);
	assign argn_c  = in_args ? arg_ext[3:0] : 4'd0;

	always_comb begin
		tag_c    = irc_tok_pkg::TAG_DELIM;
		kind_c   = irc_tok_pkg::KIND_NONE;
		closes_c = 1'b0;
		unique case (phase_q)
			irc_tok_pkg::PH_START, irc_tok_pkg::PH_CMD: begin
				if (!is_space && !(phase_q == irc_tok_pkg::PH_START &&
				                   byte_s1 == irc_tok_pkg::CH_COLON)) begin
					tag_c = irc_tok_pkg::TAG_CMD;
				end
			end
			irc_tok_pkg::PH_NAME: begin
				if (is_space) begin
					kind_c = saw_dot_q ? irc_tok_pkg::KIND_SERVER : irc_tok_pkg::KIND_NICK;
				end else if (byte_s1 != irc_tok_pkg::CH_BANG) begin
					tag_c = irc_tok_pkg::TAG_NAME;
				end
			end
			irc_tok_pkg::PH_USER: begin
				if (is_space) begin
					kind_c = irc_tok_pkg::KIND_NICK;
				end else if (byte_s1 != irc_tok_pkg::CH_AT) begin
					tag_c = irc_tok_pkg::TAG_USER;
				end
			end
			irc_tok_pkg::PH_HOST: begin
				if (is_space) begin
					kind_c = irc_tok_pkg::KIND_NICK;
				end else begin
					tag_c = irc_tok_pkg::TAG_HOST;
				end
			end
			irc_tok_pkg::PH_ARGSTART: begin
				if (is_space) begin
					closes_c = 1'b1;
				end else if (byte_s1 != irc_tok_pkg::CH_COLON) begin
					tag_c = irc_tok_pkg::TAG_ARG;
				end
			end
			irc_tok_pkg::PH_ARGBODY: begin
				if (is_space) begin
					closes_c = 1'b1;
				end else begin
					tag_c = irc_tok_pkg::TAG_ARG;
				end
			end
			irc_tok_pkg::PH_TRAIL: begin
				tag_c = irc_tok_pkg::TAG_TRAIL;
			end
			default: begin
				tag_c = irc_tok_pkg::TAG_DELIM;
			end
		endcase
	end

	// parser state, back to line start after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= irc_tok_pkg::PH_START;
			saw_dot_q      <= 1'b0;
			arg_count_q    <= '0;
			code_q         <= '0;
			digits_ended_q <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1) begin
				phase_q        <= irc_tok_pkg::PH_START;
				saw_dot_q      <= 1'b0;
				arg_count_q    <= '0;
				code_q         <= '0;
				digits_ended_q <= 1'b0;
			end else begin
				phase_q        <= phase_d;
				saw_dot_q      <= saw_dot_d;
				arg_count_q    <= arg_count_d;
				code_q         <= code_d;
				digits_ended_q <= digits_ended_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			byte_s2    <= byte_s1;
			last_s2    <= last_s1;
			tag_s2     <= tag_c;
			argn_s2    <= argn_c;
			closes_s2  <= closes_c;
			kind_s2    <= kind_c;
			invalid_s2 <= last_s1 && (phase_d == irc_tok_pkg::PH_NAME);
			code_s2    <= code_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {code_s2, invalid_s2, closes_s2, argn_s2, byte_s2};
	assign m_axis_tuser  = {kind_s2, tag_s2};
	assign m_axis_tlast  = last_s2;

endmodule
